>>> rtl/row_softmax_defines.svh
// ---------------------------------------------------------------------------
// Row softmax assertion macros
// Shared macros for the concurrent checks of the row softmax block.
// ---------------------------------------------------------------------------
`ifndef ROW_SOFTMAX_DEFINES_SVH
`define ROW_SOFTMAX_DEFINES_SVH

// Check that is switched off while reset is held.
`define RS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define RS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rsmx_pkg.sv
// ---------------------------------------------------------------------------
// Row softmax package
// Shared constants and the command and status types of the row softmax.
// ---------------------------------------------------------------------------
`default_nettype none

package rsmx_pkg;

    localparam int MAX_ROW_DEF         = 64;
    localparam int EXP_TABLE_DEPTH_DEF = 256;
    localparam int SCORE_W             = 16;
    localparam int PROB_W              = 16;
    localparam int SUM_W               = 23;
    localparam int RECIP_W             = 23;
    localparam int EXP_W               = 17;

    typedef struct packed {
        logic in_accept;
        logic clear_row;
        logic sum_clear;
        logic sum_acc;
        logic div_start;
        logic out_load;
        logic out_last;
    } t_rsmx_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_valid;
        logic out_fire;
    } t_rsmx_status;

endpackage

`default_nettype wire

>>> rtl/rsmx_datapath.sv
// ---------------------------------------------------------------------------
// Row softmax datapath
// Row store, running maximum, exponent pipeline, sum, reciprocal divider
// and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rsmx_datapath
    import rsmx_pkg::*;
#(
    parameter int MAX_ROW         = MAX_ROW_DEF,
    parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF,
    localparam int KW             = $clog2(MAX_ROW),
    localparam int CW             = $clog2(MAX_ROW + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_rsmx_cmd           i_cmd,
    input  wire logic [KW-1:0]       i_rd_addr,
    input  wire logic [SCORE_W-1:0]  i_score,
    output t_rsmx_status             o_status,
    output logic [CW-1:0]            o_count,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [PROB_W-1:0]        o_m_tdata,
    output logic                     o_m_tlast,
    output logic                     o_m_tuser
);

    localparam int IW = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [32:0] LOG2E_Q16 = 33'd94548;

    typedef logic [EXP_W-1:0] t_tab [EXP_TABLE_DEPTH];

    function automatic t_tab build_tab();
        t_tab        tb;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] rnd;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            a    = (64'(i) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
            term = 64'd1 << 32;
            acc  = term;
            for (int k = 1; k <= 12; k++) begin
                term = ((term * a) >> 32) / 64'(k);
                if ((k % 2) == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            rnd   = (acc + 64'h8000) >> 16;
            tb[i] = rnd[EXP_W-1:0];
        end
        return tb;
    endfunction

    localparam t_tab EXP_TAB = build_tab();

    logic [SCORE_W-1:0] r_mem [MAX_ROW];
    logic [SCORE_W-1:0] r_x;
    logic [32:0]        r_u;
    logic [EXP_W-1:0]   r_e;
    logic [39:0]        r_p;
    logic [CW-1:0]      r_count;
    logic [SCORE_W-1:0] r_max;
    logic [SUM_W-1:0]   r_sum;
    logic               r_ovf;
    logic [SUM_W-1:0]   r_rem;
    logic [RECIP_W-1:0] r_q;
    logic [4:0]         r_dcnt;
    logic               r_dbusy;
    logic               r_ovalid;
    logic [PROB_W-1:0]  r_odata;
    logic               r_olast;
    logic               r_ouser;

    logic [SCORE_W-1:0] w_d;
    logic [34:0]        w_fprod;
    logic [IW-1:0]      w_idx;
    logic [EXP_W-1:0]   w_e;
    logic [SUM_W:0]     w_trial;
    logic [RECIP_W-1:0] w_r;
    logic [40:0]        w_round;
    logic [18:0]        w_pq;
    logic [PROB_W-1:0]  w_prob;
    logic               w_fire;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_accept && (r_count < CW'(MAX_ROW))) begin
            r_mem[r_count[KW-1:0]] <= i_score;
        end
        r_x <= r_mem[i_rd_addr];
    end

    always_comb begin
        w_d     = r_max - r_x;
        w_fprod = 35'(r_u[23:0]) * 35'(EXP_TABLE_DEPTH);
        w_idx   = w_fprod[24 +: IW];
        if (r_u[32:24] >= 9'd17) begin
            w_e = '0;
        end else begin
            w_e = EXP_TAB[w_idx] >> r_u[28:24];
        end
        w_trial = {r_rem, 1'b0};
        w_r     = (r_sum == '0) ? '0 : r_q;
        w_round = 41'(r_p) + 41'(1 << 21);
        w_pq    = w_round[40:22];
        w_prob  = (w_pq > 19'd65535) ? 16'hFFFF : w_pq[PROB_W-1:0];
        w_fire  = r_ovalid && i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        r_u <= 33'(w_d) * LOG2E_Q16;
        r_e <= w_e;
        r_p <= 40'(r_e) * 40'(w_r);
        if (i_cmd.out_load) begin
            r_odata <= w_prob;
            r_olast <= i_cmd.out_last;
            r_ouser <= r_ovf;
        end
        if (i_cmd.div_start) begin
            r_rem <= SUM_W'(1 << 15);
        end else if (r_dbusy) begin
            if (w_trial >= {1'b0, r_sum}) begin
                r_rem <= SUM_W'(w_trial - {1'b0, r_sum});
                r_q   <= {r_q[RECIP_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[SUM_W-1:0];
                r_q   <= {r_q[RECIP_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_max    <= 16'h8000;
            r_sum    <= '0;
            r_ovf    <= 1'b0;
            r_dcnt   <= '0;
            r_dbusy  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clear_row) begin
                r_count <= '0;
                r_max   <= 16'h8000;
                r_ovf   <= 1'b0;
            end else if (i_cmd.in_accept) begin
                if (r_count < CW'(MAX_ROW)) begin
                    r_count <= r_count + 1'b1;
                    if ($signed(i_score) > $signed(r_max)) begin
                        r_max <= i_score;
                    end
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.sum_clear) begin
                r_sum <= '0;
            end else if (i_cmd.sum_acc) begin
                r_sum <= r_sum + SUM_W'(r_e);
            end
            if (i_cmd.div_start) begin
                r_dcnt  <= 5'(RECIP_W);
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == 5'd1) begin
                    r_dbusy <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (w_fire) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_status.div_busy  = r_dbusy;
    assign o_status.out_valid = r_ovalid;
    assign o_status.out_fire  = w_fire;
    assign o_count    = r_count;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ouser;

endmodule

`default_nettype wire

>>> rtl/rsmx_ctrl.sv
// ---------------------------------------------------------------------------
// Row softmax controller
// Sequences the load, sum, reciprocal and emit passes over the row store.
// ---------------------------------------------------------------------------
`default_nettype none

module rsmx_ctrl
    import rsmx_pkg::*;
#(
    parameter int MAX_ROW = MAX_ROW_DEF,
    localparam int KW     = $clog2(MAX_ROW),
    localparam int CW     = $clog2(MAX_ROW + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    input  wire logic          i_s_tlast,
    output logic               o_s_tready,
    input  wire t_rsmx_status  i_status,
    input  wire logic [CW-1:0] i_count,
    output t_rsmx_cmd          o_cmd,
    output logic [KW-1:0]      o_rd_addr
);

    typedef enum logic [3:0] {
        S_LOAD, S_RD, S_MU, S_EX, S_ACC, S_DIVS, S_DIV, S_PM, S_OUT, S_WAIT
    } t_state;

    t_state        r_state, n_state;
    logic [KW-1:0] r_k, n_k;
    logic          r_emit, n_emit;
    logic          w_last_k;

    assign w_last_k = ({1'b0, r_k} + 1'b1) == (KW + 1)'(i_count);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_emit  = r_emit;
        o_cmd   = '0;
        o_cmd.out_last = w_last_k;
        case (r_state)
            S_LOAD: begin
                o_cmd.in_accept = i_s_tvalid;
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = S_RD;
                    n_k     = '0;
                    n_emit  = 1'b0;
                    o_cmd.sum_clear = 1'b1;
                end
            end
            S_RD: n_state = S_MU;
            S_MU: n_state = S_EX;
            S_EX: n_state = r_emit ? S_PM : S_ACC;
            S_ACC: begin
                o_cmd.sum_acc = 1'b1;
                if (w_last_k) begin
                    n_state = S_DIVS;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_RD;
                end
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_RD;
                    n_k     = '0;
                    n_emit  = 1'b1;
                end
            end
            S_PM: n_state = S_OUT;
            S_OUT: begin
                o_cmd.out_load = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.out_fire) begin
                    if (w_last_k) begin
                        o_cmd.clear_row = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_k     <= '0;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_emit  <= n_emit;
        end
    end

    assign o_s_tready = (r_state == S_LOAD);
    assign o_rd_addr  = r_k;

endmodule

`default_nettype wire

>>> rtl/row_softmax.sv
// After the last score, the sum pass runs S_RD, S_MU, S_EX and S_ACC per
// element, the 23-step restoring reciprocal divider follows, then S_RD,
// S_MU, S_EX, S_PM, S_OUT and S_WAIT run per probability, where S_WAIT
// waits out any output stall. One row is worked on at a time, and loading
// takes one score per cycle. Reset is synchronous, active low, and clears
// the control state; the row store and exponent table need no clearing pass.
// ---------------------------------------------------------------------------
// Row softmax top level
// Streams a row of Q8.8 scores in and streams Q0.16 probabilities out.
// ---------------------------------------------------------------------------
`default_nettype none

module row_softmax
    import rsmx_pkg::*;
#(
    parameter int MAX_ROW         = MAX_ROW_DEF,
    parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] score
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [15:0] prob
    output logic             o_m_tlast,
    output logic             o_m_tuser    // [0] overflow
);

    localparam int KW = $clog2(MAX_ROW);
    localparam int CW = $clog2(MAX_ROW + 1);

    t_rsmx_cmd     w_cmd;
    t_rsmx_status  w_status;
    logic [KW-1:0] w_rd_addr;
    logic [CW-1:0] w_count;

    rsmx_ctrl #(.MAX_ROW(MAX_ROW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .i_count    (w_count),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr)
    );

    rsmx_datapath #(
        .MAX_ROW         (MAX_ROW),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_rd_addr  (w_rd_addr),
        .i_score    (i_s_tdata),
        .o_status   (w_status),
        .o_count    (w_count),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

>>> rtl/rsmx_checker.sv
// ---------------------------------------------------------------------------
// Row softmax port checker
// Concurrent checks on the ports of the row softmax, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "row_softmax_defines.svh"

module rsmx_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_s_tvalid,
    input wire logic o_s_tready,
    input wire logic i_s_tlast,
    input wire logic o_m_tvalid,
    input wire logic i_m_tready
);

    `RS_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "stalled result dropped")
    `RS_ASSERT(a_no_overlap, i_clk, i_rst_n, !(o_s_tready && o_m_tvalid), "input taken while a result is pending")
    `RS_ASSERT(a_close_row, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready, "input taken after row end")
    `RS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind row_softmax rsmx_checker u_rsmx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

`default_nettype wire
